/* rtl/core/tms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tms_pkg;

    localparam int ByteWidth = 8;
    localparam int IndexWidth = 3;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_WRITE   = 3'd1,
        ACT_STOP    = 3'd2,
        ACT_START   = 3'd3,
        ACT_RX_ACK  = 3'd4,
        ACT_RX_NACK = 3'd5
    } action_t;

    localparam logic [7:0] STATUS_MASK    = 8'b1111_1000;
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RESTART     = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK    = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK   = 8'h20;
    localparam logic [7:0] ST_DATA_ACK    = 8'h28;
    localparam logic [7:0] ST_DATA_NACK   = 8'h30;
    localparam logic [7:0] ST_ARB_LOST    = 8'h38;
    localparam logic [7:0] ST_SLAR_ACK    = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK   = 8'h48;
    localparam logic [7:0] ST_RXDATA_ACK  = 8'h50;
    localparam logic [7:0] ST_RXDATA_NACK = 8'h58;

    localparam logic [IndexWidth-1:0] REG_SLAVE_ADDRESS = 3'd0;
    localparam logic [IndexWidth-1:0] REG_COMMAND_BYTE  = 3'd1;
    localparam logic [IndexWidth-1:0] REG_BYTE_COUNT    = 3'd2;
    localparam logic [IndexWidth-1:0] REG_READ_MODE     = 3'd3;

    typedef struct packed {
        logic [ByteWidth-1:0] slave_address;
        logic [ByteWidth-1:0] command_byte;
        logic [ByteWidth-1:0] byte_count;
        logic                 read_mode;
    } cfg_t;

    typedef struct packed {
        action_t              bus_action;
        logic [ByteWidth-1:0] write_value;
        logic                 byte_valid;
        logic [ByteWidth-1:0] received_value;
        logic [ByteWidth-1:0] byte_index;
        logic                 finished;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/tms_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module tms_cfg_regs
    import tms_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [IndexWidth-1:0] cfg_index,
    input  wire logic [ByteWidth-1:0]  cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_SLAVE_ADDRESS: cfg_next.slave_address = cfg_wdata;
                REG_COMMAND_BYTE:  cfg_next.command_byte  = cfg_wdata;
                REG_BYTE_COUNT:    cfg_next.byte_count    = cfg_wdata;
                REG_READ_MODE:     cfg_next.read_mode     = cfg_wdata[0];
                // drop writes beyond the register list
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/tms_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module tms_decode
    import tms_pkg::*;
(
    input  wire cfg_t                 cfg,
    input  wire logic [ByteWidth-1:0] bus_status,
    input  wire logic [ByteWidth-1:0] rx_byte,
    input  wire logic [ByteWidth-1:0] tx_byte,
    input  wire logic [ByteWidth-1:0] position,
    output logic [ByteWidth-1:0]      position_next,
    output result_t                   result
);

    logic [ByteWidth-1:0] status;
    logic [ByteWidth-1:0] pos_sat_inc;
    logic [ByteWidth-1:0] pos_work;
    logic [ByteWidth-1:0] cap_index;
    action_t              action;
    logic [ByteWidth-1:0] wval;
    logic                 valid;
    logic [ByteWidth-1:0] rval;

    assign status = bus_status & STATUS_MASK;
    // hold the index at its top value while reading
    assign pos_sat_inc = (position != {ByteWidth{1'b1}}) ? position + 1'b1 : position;

    always_comb begin
        action    = ACT_NONE;
        wval      = '0;
        valid     = 1'b0;
        rval      = '0;
        cap_index = '0;
        pos_work  = position;
        if (!cfg.read_mode) begin
            unique case (status) inside
                ST_START, ST_RESTART: begin
                    action = ACT_WRITE;
                    wval   = cfg.slave_address;
                end
                ST_SLAW_ACK: begin
                    action = ACT_WRITE;
                    wval   = cfg.command_byte;
                end
                ST_SLAW_NACK, ST_DATA_NACK: begin
                    action = ACT_STOP;
                end
                ST_DATA_ACK: begin
                    if (position < cfg.byte_count) begin
                        action   = ACT_WRITE;
                        wval     = tx_byte;
                        pos_work = position + 1'b1;
                    end else begin
                        action = ACT_STOP;
                    end
                end
                ST_ARB_LOST: begin
                    action   = ACT_START;
                    pos_work = '0;
                end
                default: begin
                    action = ACT_NONE;
                end
            endcase
        end else begin
            unique case (status) inside
                ST_START, ST_RESTART: begin
                    action = ACT_WRITE;
                    wval   = cfg.slave_address + 1'b1;
                end
                ST_ARB_LOST: begin
                    action   = ACT_START;
                    pos_work = '0;
                end
                ST_SLAR_ACK: begin
                    action = (position < cfg.byte_count) ? ACT_RX_ACK : ACT_RX_NACK;
                end
                ST_SLAR_NACK: begin
                    action = ACT_STOP;
                end
                ST_RXDATA_ACK: begin
                    valid     = 1'b1;
                    rval      = rx_byte;
                    cap_index = position;
                    pos_work  = pos_sat_inc;
                    // ack the next byte unless it is the last one
                    action = (pos_sat_inc < cfg.byte_count) ? ACT_RX_ACK : ACT_RX_NACK;
                end
                ST_RXDATA_NACK: begin
                    valid     = 1'b1;
                    rval      = rx_byte;
                    cap_index = position;
                    action    = ACT_STOP;
                end
                default: begin
                    action = ACT_NONE;
                end
            endcase
        end
    end

    // every stop clears the index
    assign position_next = (action == ACT_STOP) ? '0 : pos_work;

    always_comb begin
        result.bus_action     = action;
        result.write_value    = wval;
        result.byte_valid     = valid;
        result.received_value = rval;
        result.byte_index     = valid ? cap_index : position_next;
        result.finished       = (action == ACT_STOP);
    end

endmodule

`default_nettype wire

/* rtl/core/two_wire_master_sequencer.sv */
// Two-wire master sequencer: one status request in, one bus action out.
// A request moves from the input register through the decode logic into
// the result register. Throughput: one request per cycle unless m_ready
// stalls the output; the byte index updates as a request leaves the input
// register, so the next request sees it at once.
// Reset: synchronous active-low aresetn clears valid flags, config and index.
`timescale 1ns / 1ps
`default_nettype none

module two_wire_master_sequencer
    import tms_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [IndexWidth-1:0] cfg_index,
    input  wire logic [ByteWidth-1:0]  cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ByteWidth-1:0]  s_bus_status,
    input  wire logic [ByteWidth-1:0]  s_rx_byte,
    input  wire logic [ByteWidth-1:0]  s_tx_byte,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_bus_action,
    output logic [ByteWidth-1:0]       m_write_value,
    output logic                       m_byte_valid,
    output logic [ByteWidth-1:0]       m_received_value,
    output logic [ByteWidth-1:0]       m_byte_index,
    output logic                       m_finished
);

    cfg_t                 cfg;
    logic                 in_valid_reg;
    logic [ByteWidth-1:0] status_reg;
    logic [ByteWidth-1:0] rx_reg;
    logic [ByteWidth-1:0] tx_reg;
    logic                 out_valid_reg;
    result_t              result_reg;
    result_t              result_next;
    logic [ByteWidth-1:0] position_reg;
    logic [ByteWidth-1:0] position_next;
    logic                 advance;

    tms_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tms_decode u_decode (
        .cfg           (cfg),
        .bus_status    (status_reg),
        .rx_byte       (rx_reg),
        .tx_byte       (tx_reg),
        .position      (position_reg),
        .position_next (position_next),
        .result        (result_next)
    );

    // move a request into the result register when that slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            position_reg  <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                position_reg  <= position_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            status_reg <= s_bus_status;
            rx_reg     <= s_rx_byte;
            tx_reg     <= s_tx_byte;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_bus_action     = result_reg.bus_action;
    assign m_write_value    = result_reg.write_value;
    assign m_byte_valid     = result_reg.byte_valid;
    assign m_received_value = result_reg.received_value;
    assign m_byte_index     = result_reg.byte_index;
    assign m_finished       = result_reg.finished;

endmodule

`default_nettype wire

/* rtl/core/tms_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tms_checker
    import tms_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [2:0]           m_bus_action,
    input wire logic [ByteWidth-1:0] m_write_value,
    input wire logic                 m_byte_valid,
    input wire logic [ByteWidth-1:0] m_received_value,
    input wire logic                 m_finished
);

    a_finished_on_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_finished == (m_bus_action == ACT_STOP)))
        else $error("finished does not match stop action");

    a_write_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bus_action != ACT_WRITE) |-> (m_write_value == '0))
        else $error("write value set without a write action");

    a_received_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> (m_received_value == '0))
        else $error("received value set without a captured byte");

    a_capture_action: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_byte_valid) |->
            (m_bus_action == ACT_RX_ACK || m_bus_action == ACT_RX_NACK
             || m_bus_action == ACT_STOP))
        else $error("captured byte with a non-receive action");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_bus_action)))
        else $error("stalled result changed");

endmodule

bind two_wire_master_sequencer tms_checker u_tms_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_bus_action     (m_bus_action),
    .m_write_value    (m_write_value),
    .m_byte_valid     (m_byte_valid),
    .m_received_value (m_received_value),
    .m_finished       (m_finished)
);

`default_nettype wire
